FILE: design/integer_field_formatter_top_defines.svh
// Assertion macros shared by the integer field formatter RTL.
`ifndef INTEGER_FIELD_FORMATTER_TOP_DEFINES_SVH
`define INTEGER_FIELD_FORMATTER_TOP_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define IFF_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define IFF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/iff_pkg.sv
// Types, constants and helpers shared by the integer field formatter.
package iff_pkg;

    localparam int VAL_W         = 64;
    localparam int BCD_DIGITS    = 20;
    localparam int HEX_DIGITS    = 16;
    localparam int BCD_W         = 4 * BCD_DIGITS;
    localparam int BITS_PER_STEP = 4;
    localparam int CONV_STEPS    = VAL_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(CONV_STEPS);
    localparam int NDIG_W        = 5;
    localparam int LEN_W         = 7;
    localparam int RESULT_LIMIT  = 60;

    // Conversion codes
    localparam logic [2:0] CMD_SDEC = 3'd0;
    localparam logic [2:0] CMD_UDEC = 3'd1;
    localparam logic [2:0] CMD_HEXL = 3'd2;
    localparam logic [2:0] CMD_HEXU = 3'd3;
    localparam logic [2:0] CMD_PTR  = 3'd4;

    // ASCII codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_A_LO  = 8'h61;

    typedef logic [LEN_W-1:0] t_len;

    typedef struct packed {
        logic [2:0]  command;
        logic        wide_value;
        logic [63:0] value;
        logic        left_just;
        logic        zero_fill;
        logic        show_plus;
        logic        show_space;
        logic        alt_form;
        logic [5:0]  field_width;
        logic        has_precision;
        logic [5:0]  precision;
    } t_in_item;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_out_item;

    // Sequencer commands to the digit unit
    typedef struct packed {
        logic load;
        logic hex;
        logic conv;
        logic norm;
        logic pop;
    } t_dig_ctl;

    // Digit unit status back to the sequencer
    typedef struct packed {
        logic [3:0]        top_digit;
        logic [NDIG_W-1:0] ndig;
        logic              conv_last;
        logic              norm_done;
    } t_dig_stat;

    // Map one digit to its ASCII character.
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? CH_A_UP : CH_A_LO;
        if (d < 4'd10) begin
            digit_char = CH_ZERO + {4'b0, d};
        end else begin
            digit_char = base + {4'b0, d} - 8'd10;
        end
    endfunction

endpackage

FILE: design/iff_in_if.sv
// Valid/ready channel carrying one parsed integer conversion.
interface iff_in_if;
    import iff_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: design/iff_out_if.sv
// Valid/ready channel carrying one output character.
interface iff_out_if;
    import iff_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: design/iff_digit_unit.sv
// Shared shift/add-3 digit unit: binary to BCD, normalize, digit pop.
module iff_digit_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  iff_pkg::t_dig_ctl   i_ctl,
    input  logic [63:0]         i_mag,
    output iff_pkg::t_dig_stat  o_stat
);
    import iff_pkg::*;

    logic [VAL_W-1:0]  r_bin, n_bin;
    logic [BCD_W-1:0]  r_bcd, n_bcd;
    logic [NDIG_W-1:0] r_ndig, n_ndig;
    logic [STEP_W-1:0] r_step, n_step;
    logic [VAL_W-1:0]  bin_c;
    logic [BCD_W-1:0]  bcd_c;

    // Four double-dabble bit steps per cycle
    always_comb begin
        bin_c = r_bin;
        bcd_c = r_bcd;
        for (int k = 0; k < BITS_PER_STEP; k++) begin
            for (int j = 0; j < BCD_DIGITS; j++) begin
                if (bcd_c[j*4 +: 4] >= 4'd5) begin
                    bcd_c[j*4 +: 4] = bcd_c[j*4 +: 4] + 4'd3;
                end
            end
            bcd_c = {bcd_c[BCD_W-2:0], bin_c[VAL_W-1]};
            bin_c = {bin_c[VAL_W-2:0], 1'b0};
        end
    end

    always_comb begin
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        n_ndig = r_ndig;
        n_step = r_step;
        if (i_ctl.load) begin
            n_step = '0;
            if (i_ctl.hex) begin
                n_bcd  = {i_mag, {(BCD_W-VAL_W){1'b0}}};
                n_ndig = NDIG_W'(HEX_DIGITS);
            end else begin
                n_bin  = i_mag;
                n_bcd  = '0;
                n_ndig = NDIG_W'(BCD_DIGITS);
            end
        end else if (i_ctl.conv) begin
            n_bin  = bin_c;
            n_bcd  = bcd_c;
            n_step = r_step + 1'b1;
        end else if (i_ctl.norm) begin
            n_bcd  = {r_bcd[BCD_W-5:0], 4'b0};
            n_ndig = r_ndig - 1'b1;
        end else if (i_ctl.pop) begin
            n_bcd  = {r_bcd[BCD_W-5:0], 4'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ndig <= NDIG_W'(1);
            r_step <= '0;
        end else begin
            r_ndig <= n_ndig;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_stat.top_digit = r_bcd[BCD_W-1 -: 4];
    assign o_stat.ndig      = r_ndig;
    assign o_stat.conv_last = (r_step == STEP_W'(CONV_STEPS - 1));
    assign o_stat.norm_done = (r_ndig == NDIG_W'(1)) || (r_bcd[BCD_W-1 -: 4] != 4'd0);

endmodule

FILE: design/integer_field_formatter_top.sv
// Top level of the integer field formatter: sequencer and output stage.
`include "integer_field_formatter_top_defines.svh"

// Integer field formatter. Takes one parsed printf integer conversion
// (signed or unsigned decimal, lower or upper hex, pointer) on i_cmd and
// transfers its text on o_chr, one ASCII character per transfer, with last
// set on the final character; a conversion that prints nothing transfers
// nothing. i_cmd is ready only while the block is idle, so one conversion is
// in flight at a time. Per conversion: it is taken while idle; for decimal the
// shared shift/add-3 unit converts the 64-bit magnitude four bits per cycle
// (hex skips this); the same unit then strips leading zero digits; the field
// is sized in ST_PLAN_A and ST_PLAN_B; then the characters are made section
// by section, empty sections being skipped, and the character phase stalls
// with o_chr. Width saturates at MAX_WIDTH, precision at MAX_PRECISION, and
// at most 60 characters are transferred per conversion.
module integer_field_formatter_top #(
    parameter int MAX_WIDTH     = 60,
    parameter int MAX_PRECISION = 40
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    iff_in_if.sink    i_cmd,
    iff_out_if.source o_chr
);
    import iff_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CONV   = 4'd1;
    localparam logic [3:0] ST_NORM   = 4'd2;
    localparam logic [3:0] ST_PLAN_A = 4'd3;
    localparam logic [3:0] ST_PLAN_B = 4'd4;
    localparam logic [3:0] ST_LPAD   = 4'd5;
    localparam logic [3:0] ST_SIGN   = 4'd6;
    localparam logic [3:0] ST_PFX    = 4'd7;
    localparam logic [3:0] ST_ZERO   = 4'd8;
    localparam logic [3:0] ST_DIG    = 4'd9;
    localparam logic [3:0] ST_RPAD   = 4'd10;

    // Control state
    logic [3:0] r_state, n_state;
    t_len       r_cnt, n_cnt;
    t_len       r_remain, n_remain;
    logic       r_ov, n_ov;

    // Per-conversion payload
    logic       r_has_sign;
    logic [7:0] r_sign_char;
    logic       r_prefix;
    logic       r_upper;
    logic       r_left;
    logic       r_zero_pad;
    logic       r_has_prec;
    t_len       r_prec;
    t_len       r_width;
    logic       r_val_zero;
    t_len       r_ndig;
    t_len       r_min_zeros;
    t_len       r_total;
    t_len       r_pad;
    t_len       r_zeros;
    logic [7:0] r_och;
    logic       r_olast;

    // Input decode
    logic        accept;
    logic [2:0]  cmd;
    logic        signed_dec, is_hex, is_upper, is_ptr;
    logic [63:0] val_ext, mag;
    logic        neg, has_sign_c;
    logic [7:0]  sign_char_c;
    t_len        width_raw, prec_raw, width_sat, prec_sat;

    // Field sizing
    t_len nd_c, ndig_eff_c, pz_c, total_c, pad_c, full_c, remain_c;

    // Character phase
    logic       slot, emit;
    logic [7:0] ch_c;
    logic [3:0] seg_next;
    t_len       seg_next_len;

    t_dig_ctl  dig_ctl;
    t_dig_stat dig_stat;

    assign accept      = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == ST_IDLE);

    // Normalize the argument and take its magnitude
    always_comb begin
        cmd = i_cmd.data.command;
        if (cmd > CMD_PTR) begin
            cmd = CMD_UDEC;
        end
        signed_dec = (cmd == CMD_SDEC);
        is_hex     = (cmd == CMD_HEXL) || (cmd == CMD_HEXU) || (cmd == CMD_PTR);
        is_upper   = (cmd == CMD_HEXU);
        is_ptr     = (cmd == CMD_PTR);
        val_ext    = i_cmd.data.value;
        if (!is_ptr && !i_cmd.data.wide_value) begin
            val_ext = signed_dec ? {{32{val_ext[31]}}, val_ext[31:0]}
                                 : {32'b0, val_ext[31:0]};
        end
        neg = signed_dec && val_ext[63];
        mag = neg ? (64'd0 - val_ext) : val_ext;
        has_sign_c  = neg || (signed_dec && (i_cmd.data.show_plus || i_cmd.data.show_space));
        sign_char_c = neg ? CH_MINUS : (i_cmd.data.show_plus ? CH_PLUS : CH_SPACE);
        width_raw = {1'b0, i_cmd.data.field_width};
        prec_raw  = {1'b0, i_cmd.data.precision};
        width_sat = (width_raw > t_len'(MAX_WIDTH)) ? t_len'(MAX_WIDTH) : width_raw;
        prec_sat  = (prec_raw > t_len'(MAX_PRECISION)) ? t_len'(MAX_PRECISION) : prec_raw;
    end

    // First sizing cycle: digit count and precision zeros
    always_comb begin
        nd_c       = t_len'(dig_stat.ndig);
        ndig_eff_c = (r_has_prec && (r_prec == '0) && r_val_zero) ? '0 : nd_c;
        pz_c       = (r_has_prec && (r_prec > nd_c)) ? (r_prec - nd_c) : '0;
        total_c    = t_len'(r_has_sign) + (r_prefix ? t_len'(2) : '0) + pz_c + ndig_eff_c;
    end

    // Second sizing cycle: padding and character budget
    always_comb begin
        pad_c    = (r_width > r_total) ? (r_width - r_total) : '0;
        full_c   = (r_width > r_total) ? r_width : r_total;
        remain_c = (full_c > t_len'(RESULT_LIMIT)) ? t_len'(RESULT_LIMIT) : full_c;
    end

    // Section that follows the current one, with its length
    always_comb begin
        case (r_state)
            ST_LPAD: begin
                seg_next     = ST_SIGN;
                seg_next_len = t_len'(r_has_sign);
            end
            ST_SIGN: begin
                seg_next     = ST_PFX;
                seg_next_len = r_prefix ? t_len'(2) : '0;
            end
            ST_PFX: begin
                seg_next     = ST_ZERO;
                seg_next_len = r_zeros;
            end
            ST_ZERO: begin
                seg_next     = ST_DIG;
                seg_next_len = r_ndig;
            end
            ST_DIG: begin
                seg_next     = ST_RPAD;
                seg_next_len = r_left ? r_pad : '0;
            end
            default: begin
                seg_next     = ST_IDLE;
                seg_next_len = '0;
            end
        endcase
    end

    // Character of the current section
    always_comb begin
        case (r_state)
            ST_SIGN: ch_c = r_sign_char;
            ST_PFX:  ch_c = (r_cnt == t_len'(2)) ? CH_ZERO : (r_upper ? CH_X_UP : CH_X_LO);
            ST_ZERO: ch_c = CH_ZERO;
            ST_DIG:  ch_c = digit_char(dig_stat.top_digit, r_upper);
            default: ch_c = CH_SPACE;
        endcase
    end

    assign slot = !r_ov || o_chr.ready;

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_remain = r_remain;
        emit     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = is_hex ? ST_NORM : ST_CONV;
                end
            end
            ST_CONV: begin
                if (dig_stat.conv_last) begin
                    n_state = ST_NORM;
                end
            end
            ST_NORM: begin
                if (dig_stat.norm_done) begin
                    n_state = ST_PLAN_A;
                end
            end
            ST_PLAN_A: begin
                n_state = ST_PLAN_B;
            end
            ST_PLAN_B: begin
                n_remain = remain_c;
                n_cnt    = (!r_left && !r_zero_pad) ? pad_c : '0;
                n_state  = (remain_c == '0) ? ST_IDLE : ST_LPAD;
            end
            ST_LPAD, ST_SIGN, ST_PFX, ST_ZERO, ST_DIG, ST_RPAD: begin
                if (r_cnt == '0) begin
                    // skip an empty section
                    n_state = seg_next;
                    n_cnt   = seg_next_len;
                end else if (slot) begin
                    emit     = 1'b1;
                    n_remain = r_remain - 1'b1;
                    if (r_remain == t_len'(1)) begin
                        n_state = ST_IDLE;
                    end else if (r_cnt == t_len'(1)) begin
                        n_state = seg_next;
                        n_cnt   = seg_next_len;
                    end else begin
                        n_cnt = r_cnt - 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output register: hold until transferred, reload when a character is made
    always_comb begin
        n_ov = r_ov;
        if (emit) begin
            n_ov = 1'b1;
        end else if (o_chr.ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_remain <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_remain <= n_remain;
            r_ov     <= n_ov;
        end
    end

    // Capture the conversion and the sizing results
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_has_sign  <= has_sign_c;
            r_sign_char <= sign_char_c;
            r_prefix    <= is_ptr || (is_hex && i_cmd.data.alt_form && (val_ext != 64'd0));
            r_upper     <= is_upper;
            r_left      <= i_cmd.data.left_just;
            r_zero_pad  <= i_cmd.data.zero_fill && !i_cmd.data.has_precision
                           && !i_cmd.data.left_just;
            r_has_prec  <= i_cmd.data.has_precision;
            r_prec      <= prec_sat;
            r_width     <= width_sat;
            r_val_zero  <= (val_ext == 64'd0);
        end
        if (r_state == ST_PLAN_A) begin
            r_ndig      <= ndig_eff_c;
            r_min_zeros <= pz_c;
            r_total     <= total_c;
        end
        if (r_state == ST_PLAN_B) begin
            r_pad   <= pad_c;
            r_zeros <= r_min_zeros + (r_zero_pad ? pad_c : '0);
        end
        if (emit) begin
            r_och   <= ch_c;
            r_olast <= (r_remain == t_len'(1));
        end
    end

    assign dig_ctl.load = accept;
    assign dig_ctl.hex  = is_hex;
    assign dig_ctl.conv = (r_state == ST_CONV);
    assign dig_ctl.norm = (r_state == ST_NORM) && !dig_stat.norm_done;
    assign dig_ctl.pop  = emit && (r_state == ST_DIG);

    iff_digit_unit u_digit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (dig_ctl),
        .i_mag   (mag),
        .o_stat  (dig_stat)
    );

    assign o_chr.valid          = r_ov;
    assign o_chr.data.character = r_och;
    assign o_chr.data.last      = r_olast;

    `IFF_ASSERT_NEXT(a_accept_starts, accept, (r_state == ST_CONV) || (r_state == ST_NORM), "conversion did not start after accept")
    `IFF_ASSERT_IMPLIES(a_digits_normalized, r_state == ST_PLAN_A, dig_stat.norm_done, "leading digit not normalized at sizing")
    `IFF_ASSERT_IMPLIES(a_budget_limit, r_state != ST_IDLE, r_remain <= t_len'(RESULT_LIMIT), "character budget over limit")
    `IFF_ASSERT_NEXT(a_last_ends, emit && (r_remain == t_len'(1)), (r_state == ST_IDLE) && r_ov && r_olast, "final character not marked or sequencer busy")

endmodule

FILE: sim/integer_field_formatter_checker.sv
// Checker for the integer field formatter: predicts each field and compares every character.
`timescale 1ns / 1ps

module integer_field_formatter_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    iff_in_if    i_cmd,
    iff_out_if   i_chr,
    output int   o_fail_count,
    output int   o_pending
);
    import iff_pkg::*;

    localparam int MAX_WIDTH     = 60;
    localparam int MAX_PRECISION = 40;
    localparam int REPORT_LIMIT  = 10;

    t_out_item expected_chars[$];
    int        fail_cnt = 0;

    // Append the characters of one conversion to the expected stream.
    function automatic void predict_field(input t_in_item it);
        logic [2:0]  cmd;
        logic        signed_dec, is_hex, upper, is_ptr, zero_pad, prefix;
        logic [63:0] mag, v, radix;
        logic [7:0]  sign_ch;
        logic [7:0]  digits[0:23];
        string       digit_set;
        int          ndig, width, prec, min_zeros, lead_len, total, padding, zeros, i;
        t_out_item   field[$];
        cmd = it.command;
        if (cmd > CMD_PTR) cmd = CMD_UDEC;
        signed_dec = (cmd == CMD_SDEC);
        is_hex     = (cmd == CMD_HEXL) || (cmd == CMD_HEXU) || (cmd == CMD_PTR);
        upper      = (cmd == CMD_HEXU);
        is_ptr     = (cmd == CMD_PTR);
        width = (int'(it.field_width) > MAX_WIDTH) ? MAX_WIDTH : int'(it.field_width);
        prec  = (int'(it.precision) > MAX_PRECISION) ? MAX_PRECISION : int'(it.precision);
        zero_pad = it.zero_fill;

        mag = it.value;
        if (!is_ptr && !it.wide_value) begin
            mag = {32'h0, mag[31:0]};
            if (signed_dec && mag[31]) mag[63:32] = 32'hFFFF_FFFF;
        end

        sign_ch = 8'h00;
        if (signed_dec) begin
            if (mag[63]) begin
                sign_ch = CH_MINUS;
                mag     = 64'd0 - mag;
            end else if (it.show_plus) begin
                sign_ch = CH_PLUS;
            end else if (it.show_space) begin
                sign_ch = CH_SPACE;
            end
        end

        digit_set = upper ? "0123456789ABCDEF" : "0123456789abcdef";
        radix = is_hex ? 64'd16 : 64'd10;
        v     = mag;
        ndig  = 0;
        if (v == 64'd0) begin
            digits[0] = CH_ZERO;
            ndig      = 1;
        end
        while (v != 64'd0 && ndig < 24) begin
            digits[ndig] = digit_set[int'(v % radix)];
            ndig++;
            v = v / radix;
        end

        min_zeros = 0;
        if (it.has_precision) begin
            zero_pad = 1'b0;
            if (prec > ndig) min_zeros = prec - ndig;
            if (prec == 0 && mag == 64'd0) ndig = 0;
        end
        if (it.left_just) zero_pad = 1'b0;

        prefix   = is_ptr || (is_hex && it.alt_form && mag != 64'd0);
        lead_len = (sign_ch != 8'h00) ? 1 : 0;
        if (prefix) lead_len += 2;
        total   = lead_len + min_zeros + ndig;
        padding = (width > total) ? width - total : 0;

        if (!it.left_just && !zero_pad)
            for (i = 0; i < padding; i++) field.push_back('{character: CH_SPACE, last: 1'b0});
        if (sign_ch != 8'h00) field.push_back('{character: sign_ch, last: 1'b0});
        if (prefix) begin
            field.push_back('{character: CH_ZERO, last: 1'b0});
            field.push_back('{character: (upper ? CH_X_UP : CH_X_LO), last: 1'b0});
        end
        zeros = min_zeros + (zero_pad ? padding : 0);
        for (i = 0; i < zeros; i++) field.push_back('{character: CH_ZERO, last: 1'b0});
        for (i = ndig - 1; i >= 0; i--) field.push_back('{character: digits[i], last: 1'b0});
        if (it.left_just)
            for (i = 0; i < padding; i++) field.push_back('{character: CH_SPACE, last: 1'b0});

        // Drop anything past the per-conversion character limit.
        while (field.size() > RESULT_LIMIT) void'(field.pop_back());
        if (field.size() > 0) begin
            field[field.size() - 1].last = 1'b1;
            foreach (field[k]) expected_chars.push_back(field[k]);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            // Compare the character first so an output cannot match a same-edge command.
            if (i_chr.valid && i_chr.ready) begin
                if (expected_chars.size() == 0) begin
                    if (fail_cnt < REPORT_LIMIT)
                        $display("%0t: character %h last %b arrived with nothing pending",
                                 $realtime, i_chr.data.character, i_chr.data.last);
                    fail_cnt++;
                end else begin
                    want = expected_chars.pop_front();
                    if (i_chr.data.character !== want.character
                            || i_chr.data.last !== want.last) begin
                        if (fail_cnt < REPORT_LIMIT)
                            $display("%0t: mismatch: expected char %h last %b, got char %h last %b",
                                     $realtime, want.character, want.last,
                                     i_chr.data.character, i_chr.data.last);
                        fail_cnt++;
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready) predict_field(i_cmd.data);
        end
        o_fail_count <= fail_cnt;
        o_pending    <= expected_chars.size();
    end

endmodule

FILE: sim/tb_integer_field_formatter_top.sv
// Testbench top for the integer field formatter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_integer_field_formatter_top;
    import iff_pkg::*;

    localparam int RESET_CYCLES     = 7;
    // Conversions that print nothing (empty fields) give no transfer, so wait
    // long enough for the block to finish one after the last character.
    localparam int DRAIN_CYCLES     = 150;
    localparam int RANDOM_PER_PHASE = 24;
    localparam int NUM_PHASES       = 4;

    // Flag masks for building conversions: left, zero, plus, space, hash.
    localparam logic [4:0] FL_NONE  = 5'b00000;
    localparam logic [4:0] FL_LEFT  = 5'b10000;
    localparam logic [4:0] FL_ZERO  = 5'b01000;
    localparam logic [4:0] FL_PLUS  = 5'b00100;
    localparam logic [4:0] FL_SPACE = 5'b00010;
    localparam logic [4:0] FL_HASH  = 5'b00001;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic chr_ready = 1'b0;
    int   send_idle_pct = 0;
    int   chr_stall_pct = 0;
    int   fail_count;
    int   pending;

    iff_in_if  cmd_if ();
    iff_out_if chr_if ();

    integer_field_formatter_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_chr   (chr_if)
    );

    integer_field_formatter_checker field_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_if),
        .i_chr        (chr_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Receiver: stall the character channel at the rate of the current phase.
    assign chr_if.ready = chr_ready;
    always @(posedge i_clk) begin
        chr_ready <= i_rst_n && ($urandom_range(99) >= chr_stall_pct);
    end

    // Build one conversion from its parts.
    function automatic t_in_item conversion(input logic [2:0] cmd, input logic wide,
                                            input logic [63:0] value, input logic [4:0] flags,
                                            input logic [5:0] width, input logic has_prec,
                                            input logic [5:0] prec);
        t_in_item it;
        it.command       = cmd;
        it.wide_value    = wide;
        it.value         = value;
        it.left_just     = flags[4];
        it.zero_fill     = flags[3];
        it.show_plus     = flags[2];
        it.show_space    = flags[1];
        it.alt_form      = flags[0];
        it.field_width   = width;
        it.has_precision = has_prec;
        it.precision     = prec;
        return it;
    endfunction

    // Random conversion: mostly legal commands and short fields, with the
    // odd unknown command, saturating width or precision, and edge values.
    function automatic t_in_item random_conversion();
        t_in_item    it;
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        it  = raw[$bits(t_in_item)-1:0];
        it.command = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5))
                                              : 3'($urandom_range(4));
        case ($urandom_range(5))
            0: it.value = {$urandom, $urandom};
            1: it.value = 64'($urandom_range(999));
            2: it.value = 64'd0;
            3: it.value = 64'd0 - 64'($urandom_range(1000));
            4: begin
                case ($urandom_range(3))
                    0: it.value = 64'h8000_0000_0000_0000;
                    1: it.value = 64'h7FFF_FFFF_FFFF_FFFF;
                    2: it.value = 64'hFFFF_FFFF_FFFF_FFFF;
                    default: it.value = 64'h0000_0000_8000_0000;
                endcase
            end
            default: it.value = {32'($urandom), 32'($urandom_range(65535))};
        endcase
        it.field_width = ($urandom_range(3) == 0) ? 6'($urandom_range(63))
                                                  : 6'($urandom_range(16));
        it.precision   = ($urandom_range(3) == 0) ? 6'($urandom_range(63))
                                                  : 6'($urandom_range(20));
        return it;
    endfunction

    // Offer one conversion and hold it until the block takes the transfer.
    task automatic send_conversion(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= it;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
    endtask

    // Drop valid, wait until every predicted character has arrived, then
    // give the block time to finish any conversion that prints nothing.
    task automatic drain_block();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        cmd_if.valid <= 1'b0;
        cmd_if.data  <= '0;
        i_rst_n      <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, no idling.
        // Most negative 32-bit and 64-bit signed values.
        send_conversion(conversion(CMD_SDEC, 1'b0, 64'h0000_0000_8000_0000, FL_NONE,
                                   6'd0, 1'b0, 6'd0));
        send_conversion(conversion(CMD_SDEC, 1'b1, 64'h8000_0000_0000_0000, FL_NONE,
                                   6'd0, 1'b0, 6'd0));
        // Largest positive with plus, plus beats space, space alone.
        send_conversion(conversion(CMD_SDEC, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, FL_PLUS,
                                   6'd0, 1'b0, 6'd0));
        send_conversion(conversion(CMD_SDEC, 1'b0, 64'd5, FL_PLUS | FL_SPACE,
                                   6'd4, 1'b0, 6'd0));
        send_conversion(conversion(CMD_SDEC, 1'b0, 64'd5, FL_SPACE, 6'd0, 1'b0, 6'd0));
        // Unsigned: full 20 digits; narrow ignores the upper word.
        send_conversion(conversion(CMD_UDEC, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, FL_NONE,
                                   6'd0, 1'b0, 6'd0));
        send_conversion(conversion(CMD_UDEC, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, FL_PLUS,
                                   6'd12, 1'b0, 6'd0));
        // Hex with prefix and zero padding; upper, left-justified; zero gets no prefix.
        send_conversion(conversion(CMD_HEXL, 1'b0, 64'h0000_0000_DEAD_BEEF,
                                   FL_HASH | FL_ZERO, 6'd20, 1'b0, 6'd0));
        send_conversion(conversion(CMD_HEXU, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
                                   FL_HASH | FL_LEFT, 6'd40, 1'b0, 6'd0));
        send_conversion(conversion(CMD_HEXL, 1'b1, 64'd0, FL_HASH, 6'd6, 1'b0, 6'd0));
        // Pointer ignores the width select and always has its prefix.
        send_conversion(conversion(CMD_PTR, 1'b0, 64'h1234_5678_9ABC_DEF0, FL_NONE,
                                   6'd0, 1'b0, 6'd0));
        send_conversion(conversion(CMD_PTR, 1'b1, 64'd0, FL_ZERO | FL_PLUS,
                                   6'd60, 1'b0, 6'd0));
        // Zero at precision zero: empty field, sign only, padding only.
        send_conversion(conversion(CMD_UDEC, 1'b0, 64'd0, FL_NONE, 6'd0, 1'b1, 6'd0));
        send_conversion(conversion(CMD_SDEC, 1'b0, 64'd0, FL_PLUS, 6'd0, 1'b1, 6'd0));
        send_conversion(conversion(CMD_HEXU, 1'b1, 64'd0, FL_HASH, 6'd5, 1'b1, 6'd0));
        // Zero flag dropped under precision and under left-justify.
        send_conversion(conversion(CMD_SDEC, 1'b0, 64'd0 - 64'd42, FL_ZERO,
                                   6'd10, 1'b1, 6'd5));
        send_conversion(conversion(CMD_SDEC, 1'b0, 64'd42, FL_ZERO | FL_LEFT,
                                   6'd10, 1'b0, 6'd0));
        // Unknown commands act as unsigned decimal.
        send_conversion(conversion(3'd5, 1'b0, 64'hFFFF_FFFF_FFFF_FFFE, FL_HASH,
                                   6'd0, 1'b0, 6'd0));
        send_conversion(conversion(3'd6, 1'b1, 64'h8000_0000_0000_0000, FL_PLUS,
                                   6'd0, 1'b0, 6'd0));
        send_conversion(conversion(3'd7, 1'b0, 64'd255, FL_SPACE, 6'd0, 1'b0, 6'd0));
        // Saturating width and precision; longest fields.
        send_conversion(conversion(CMD_UDEC, 1'b1, 64'd1, FL_NONE, 6'd63, 1'b1, 6'd63));
        send_conversion(conversion(CMD_SDEC, 1'b1, 64'd0 - 64'd7, FL_LEFT,
                                   6'd60, 1'b1, 6'd40));
        send_conversion(conversion(CMD_HEXU, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, FL_HASH,
                                   6'd0, 1'b1, 6'd40));
        send_conversion(conversion(CMD_SDEC, 1'b0, 64'hFFFF_FFFF, FL_ZERO | FL_PLUS,
                                   6'd20, 1'b0, 6'd0));

        // Random part: no idling, sender idle, receiver stalling, both.
        // Pause until the block is empty between phases.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain_block();
            case (phase)
                0: begin send_idle_pct = 0;  chr_stall_pct = 0;  end
                1: begin send_idle_pct = 71; chr_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  chr_stall_pct = 71; end
                default: begin send_idle_pct = 27; chr_stall_pct = 27; end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++) send_conversion(random_conversion());
        end

        drain_block();
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Hard limit on run time, far past the slowest correct run.
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/iff_pkg.sv
design/iff_in_if.sv
design/iff_out_if.sv
design/iff_digit_unit.sv
design/integer_field_formatter_top.sv
sim/integer_field_formatter_checker.sv
sim/tb_integer_field_formatter_top.sv
